>>> rtl/core/signed_speed_command_parser_top_macros.svh
// Assertion macros used by the parser top level.
`ifndef SIGNED_SPEED_COMMAND_PARSER_TOP_MACROS_SVH
`define SIGNED_SPEED_COMMAND_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SSCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sscp_pkg.sv
`default_nettype none

package sscp_pkg;

    localparam int LINE_MAX_DEFAULT = 10;

    localparam int SPEED_W = 12;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] CR_BYTE    = 8'd13;
    localparam logic [BYTE_W-1:0] ARM_BYTE   = 8'h62;  // 'b'
    localparam logic [BYTE_W-1:0] PLUS_BYTE  = 8'h2B;  // '+'
    localparam logic [BYTE_W-1:0] MINUS_BYTE = 8'h2D;  // '-'
    localparam logic [BYTE_W-1:0] ZERO_BYTE  = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] NINE_BYTE  = 8'h39;  // '9'

    localparam logic [SPEED_W-1:0] MAG_MAX = 12'd4095;

    localparam logic signed [SPEED_W-1:0] SPEED_LOW_RESET  = -12'sd2048;
    localparam logic signed [SPEED_W-1:0] SPEED_HIGH_RESET = 12'sd2047;

    // Register indexes on the configuration port.
    localparam logic REG_SPEED_LOW  = 1'b0;
    localparam logic REG_SPEED_HIGH = 1'b1;

    typedef enum logic [1:0] {
        SIGN_NONE  = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd2,
        SIGN_BAD   = 2'd3
    } sign_t;

    // Line state that does not depend on the line length.
    typedef struct packed {
        logic                armed;
        sign_t               sign_seen;
        logic                digits_open;
        logic [SPEED_W-1:0]  magnitude;
        logic signed [SPEED_W-1:0] target;
    } parse_state_t;

    typedef struct packed {
        logic                      armed_flag;
        logic                      target_updated;
        logic signed [SPEED_W-1:0] target_speed;
        logic [BYTE_W-1:0]         echo_byte;
    } result_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_low;
        logic signed [SPEED_W-1:0] speed_high;
    } limits_t;

endpackage

`default_nettype wire

>>> rtl/core/sscp_cfg.sv
`default_nettype none

module sscp_cfg (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output sscp_pkg::limits_t         limits
);

    logic signed [sscp_pkg::SPEED_W-1:0] speed_low_reg;
    logic signed [sscp_pkg::SPEED_W-1:0] speed_high_reg;
    logic                                wr_en;
    logic                                reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    // Registers are word aligned; the byte offset bits do not select anything.
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_low_reg  <= sscp_pkg::SPEED_LOW_RESET;
            speed_high_reg <= sscp_pkg::SPEED_HIGH_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                sscp_pkg::REG_SPEED_LOW:  speed_low_reg  <= pwdata[sscp_pkg::SPEED_W-1:0];
                sscp_pkg::REG_SPEED_HIGH: speed_high_reg <= pwdata[sscp_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            sscp_pkg::REG_SPEED_LOW:
                prdata = {{(32-sscp_pkg::SPEED_W){speed_low_reg[sscp_pkg::SPEED_W-1]}},
                          speed_low_reg};
            sscp_pkg::REG_SPEED_HIGH:
                prdata = {{(32-sscp_pkg::SPEED_W){speed_high_reg[sscp_pkg::SPEED_W-1]}},
                          speed_high_reg};
            default: prdata = '0;
        endcase
    end

    assign limits.speed_low  = speed_low_reg;
    assign limits.speed_high = speed_high_reg;

endmodule

`default_nettype wire

>>> rtl/core/sscp_step.sv
`default_nettype none

module sscp_step #(
    parameter int LINE_MAX = sscp_pkg::LINE_MAX_DEFAULT,
    parameter int COUNT_W  = $clog2(LINE_MAX + 1)
) (
    input  wire logic [sscp_pkg::BYTE_W-1:0] rx_byte,
    input  wire sscp_pkg::limits_t           limits,
    input  wire sscp_pkg::parse_state_t      state,
    input  wire logic [COUNT_W-1:0]          line_count,
    output sscp_pkg::parse_state_t           state_next,
    output logic [COUNT_W-1:0]               line_count_next,
    output sscp_pkg::result_t                result
);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(LINE_MAX);

    logic                                is_digit;
    logic [15:0]                         mag_acc;
    logic signed [sscp_pkg::SPEED_W:0]   value;
    logic signed [sscp_pkg::SPEED_W:0]   low_ext;
    logic signed [sscp_pkg::SPEED_W:0]   high_ext;
    logic                                in_range;
    logic                                updated;

    assign is_digit = (rx_byte >= sscp_pkg::ZERO_BYTE) && (rx_byte <= sscp_pkg::NINE_BYTE);

    // magnitude * 10 + digit, as two shifts and two adds.
    assign mag_acc = ({4'd0, state.magnitude} << 3) + ({4'd0, state.magnitude} << 1)
                   + {12'd0, rx_byte[3:0]};

    assign value = (state.sign_seen == sscp_pkg::SIGN_MINUS)
                 ? -$signed({1'b0, state.magnitude})
                 :  $signed({1'b0, state.magnitude});
    assign low_ext  = {limits.speed_low[sscp_pkg::SPEED_W-1], limits.speed_low};
    assign high_ext = {limits.speed_high[sscp_pkg::SPEED_W-1], limits.speed_high};
    assign in_range = (value >= low_ext) && (value <= high_ext);

    always_comb
    begin
        state_next      = state;
        line_count_next = line_count;
        updated         = 1'b0;

        if (rx_byte == sscp_pkg::CR_BYTE)
        begin
            if (state.armed)
            begin
                if ((state.sign_seen == sscp_pkg::SIGN_PLUS ||
                     state.sign_seen == sscp_pkg::SIGN_MINUS) && in_range)
                begin
                    state_next.target = value[sscp_pkg::SPEED_W-1:0];
                    updated           = 1'b1;
                end
                state_next.armed       = 1'b0;
                state_next.sign_seen   = sscp_pkg::SIGN_NONE;
                state_next.digits_open = 1'b1;
                state_next.magnitude   = '0;
                line_count_next        = '0;
            end
        end
        else if (rx_byte == sscp_pkg::ARM_BYTE)
        begin
            state_next.armed       = 1'b1;
            state_next.sign_seen   = sscp_pkg::SIGN_NONE;
            state_next.digits_open = 1'b1;
            state_next.magnitude   = '0;
            line_count_next        = '0;
        end
        else if (line_count >= COUNT_LIMIT)
        begin
            // A full line is thrown away together with the byte.
            state_next.sign_seen   = sscp_pkg::SIGN_NONE;
            state_next.digits_open = 1'b1;
            state_next.magnitude   = '0;
            line_count_next        = '0;
        end
        else
        begin
            if (line_count == '0)
            begin
                if (rx_byte == sscp_pkg::PLUS_BYTE)
                    state_next.sign_seen = sscp_pkg::SIGN_PLUS;
                else if (rx_byte == sscp_pkg::MINUS_BYTE)
                    state_next.sign_seen = sscp_pkg::SIGN_MINUS;
                else
                    state_next.sign_seen = sscp_pkg::SIGN_BAD;
            end
            else if (state.digits_open)
            begin
                if (is_digit)
                    state_next.magnitude = (mag_acc > {4'd0, sscp_pkg::MAG_MAX})
                                         ? sscp_pkg::MAG_MAX
                                         : mag_acc[sscp_pkg::SPEED_W-1:0];
                else
                    state_next.digits_open = 1'b0;
            end
            line_count_next = line_count + COUNT_W'(1);
        end
    end

    assign result.echo_byte      = rx_byte;
    assign result.target_speed   = state_next.target;
    assign result.target_updated = updated;
    assign result.armed_flag     = state_next.armed;

endmodule

`default_nettype wire

>>> rtl/core/signed_speed_command_parser_top.sv
// Signed speed command parser.
// Bytes from a serial receiver enter on the s_ channel; every accepted byte
// produces exactly one transaction on the m_ channel carrying the echoed byte,
// the current target speed, a flag that the byte committed a new target, and
// the armed state. 'b' arms the parser; a signed decimal line ended by a
// carriage return sets the target when it lies within speed_low..speed_high.
// A byte accepted at a clock edge is loaded into the output register at that
// edge and is valid on the m_ channel from the next cycle on. Throughput is
// one byte per cycle; the whole per-byte update (a multiply by ten, an add
// and two limit compares) sits between the state registers and the output
// register. While the output register holds a transaction that the receiver
// stalls, s_tready stays low; it rises again in the cycle the result is
// taken, so a steady stream keeps moving as long as m_tready is high.
// Reset clears the line, disarms the parser, sets the target to zero and the
// limits to -2048 and 2047. The user must write the limits over the APB port
// only while idle; the block itself leaves this unchecked.
`default_nettype none

`include "signed_speed_command_parser_top_macros.svh"

module signed_speed_command_parser_top #(
    parameter int LINE_MAX = sscp_pkg::LINE_MAX_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] echo_byte, [19:8] target_speed, [20] target_updated,
    // [21] armed_flag, [23:22] zero
    output logic [23:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int COUNT_W = $clog2(LINE_MAX + 1);

    sscp_pkg::limits_t      limits;
    sscp_pkg::parse_state_t state_reg;
    sscp_pkg::parse_state_t state_next;
    logic [COUNT_W-1:0]     line_count_reg;
    logic [COUNT_W-1:0]     line_count_next;
    sscp_pkg::result_t      result_next;
    sscp_pkg::result_t      result_reg;
    logic                   m_tvalid_reg;
    logic                   in_accept;

    sscp_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    sscp_step #(
        .LINE_MAX (LINE_MAX),
        .COUNT_W  (COUNT_W)
    ) u_step (
        .rx_byte         (s_tdata),
        .limits          (limits),
        .state           (state_reg),
        .line_count      (line_count_reg),
        .state_next      (state_next),
        .line_count_next (line_count_next),
        .result          (result_next)
    );

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.armed       <= 1'b0;
            state_reg.sign_seen   <= sscp_pkg::SIGN_NONE;
            state_reg.digits_open <= 1'b1;
            state_reg.magnitude   <= '0;
            state_reg.target      <= '0;
            line_count_reg        <= '0;
            m_tvalid_reg          <= 1'b0;
        end
        else if (in_accept)
        begin
            state_reg      <= state_next;
            line_count_reg <= line_count_next;
            m_tvalid_reg   <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, result_reg.armed_flag, result_reg.target_updated,
                       result_reg.target_speed, result_reg.echo_byte};

    `SSCP_ASSERT_NOW(a_update_disarms, m_tvalid && result_reg.target_updated, !result_reg.armed_flag, "target committed while still armed")
    `SSCP_ASSERT_NOW(a_update_in_limits, m_tvalid && result_reg.target_updated, (result_reg.target_speed >= limits.speed_low) && (result_reg.target_speed <= limits.speed_high), "committed target outside limits")
    `SSCP_ASSERT_NEXT(a_accept_gives_result, in_accept, m_tvalid && (result_reg.echo_byte == $past(s_tdata)), "accepted byte did not reach the output")
    `SSCP_ASSERT_NEXT(a_cr_disarms, in_accept && (s_tdata == sscp_pkg::CR_BYTE), !state_reg.armed && (line_count_reg == $past(state_reg.armed ? '0 : line_count_reg)), "carriage return left parser armed or line altered")

endmodule

`default_nettype wire

>>> tb/tb_signed_speed_command_parser_top.sv
`default_nettype none

module tb_signed_speed_command_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sscp_pkg::*;

    localparam int STALL_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 220;
    localparam int NUM_PHASES     = 7;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    signed_speed_command_parser_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Parser state as seen from outside, advanced on every accepted byte.
    logic                      p_armed;
    logic [3:0]                p_len;
    sign_t                     p_sign;
    logic                      p_open;
    logic [SPEED_W-1:0]        p_mag;
    logic signed [SPEED_W-1:0] p_target;
    logic signed [SPEED_W-1:0] lim_low;
    logic signed [SPEED_W-1:0] lim_high;

    result_t reply_q [$];
    int      errors = 0;
    int      phase_items;
    int      idle_cycles = 0;
    bit      snd_idle_en;
    bit      rcv_idle_en;
    bit      stall_req;

    typedef struct {
        logic [7:0]                rx;
        bit                        typed;
        logic signed [SPEED_W-1:0] tgt;
        bit                        upd;
        bit                        arm;
    } cmd_row_t;

    // Known answers are filled in only where they are obvious; the other rows
    // are checked against the line parser below.
    cmd_row_t cmd_rows [29] = '{
        '{8'h00,      1, 12'sd0,     0, 0},
        '{CR_BYTE,    1, 12'sd0,     0, 0},
        '{ARM_BYTE,   1, 12'sd0,     0, 1},
        '{PLUS_BYTE,  0, 12'sd0,     0, 0},
        '{"2",        0, 12'sd0,     0, 0},
        '{"0",        0, 12'sd0,     0, 0},
        '{"4",        0, 12'sd0,     0, 0},
        '{"7",        0, 12'sd0,     0, 0},
        '{CR_BYTE,    1, 12'sd2047,  1, 0},
        '{ARM_BYTE,   1, 12'sd2047,  0, 1},
        '{MINUS_BYTE, 0, 12'sd0,     0, 0},
        '{"2",        0, 12'sd0,     0, 0},
        '{"0",        0, 12'sd0,     0, 0},
        '{"4",        0, 12'sd0,     0, 0},
        '{"8",        0, 12'sd0,     0, 0},
        '{CR_BYTE,    1, -12'sd2048, 1, 0},
        '{ARM_BYTE,   1, -12'sd2048, 0, 1},
        '{MINUS_BYTE, 0, 12'sd0,     0, 0},
        '{CR_BYTE,    1, 12'sd0,     1, 0},
        '{ARM_BYTE,   1, 12'sd0,     0, 1},
        '{8'hFF,      0, 12'sd0,     0, 0},
        '{CR_BYTE,    1, 12'sd0,     0, 0},
        '{ARM_BYTE,   1, 12'sd0,     0, 1},
        '{PLUS_BYTE,  0, 12'sd0,     0, 0},
        '{"5",        0, 12'sd0,     0, 0},
        '{"0",        0, 12'sd0,     0, 0},
        '{"0",        0, 12'sd0,     0, 0},
        '{"0",        0, 12'sd0,     0, 0},
        '{CR_BYTE,    1, 12'sd0,     0, 0}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic void clear_line();
        p_len  = '0;
        p_sign = SIGN_NONE;
        p_open = 1'b1;
        p_mag  = '0;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] c);
        result_t r;
        int      v;
        int      m;
        r = '0;
        if (c == CR_BYTE)
        begin
            if (p_armed)
            begin
                if (p_sign == SIGN_PLUS || p_sign == SIGN_MINUS)
                begin
                    v = (p_sign == SIGN_MINUS) ? -int'(p_mag) : int'(p_mag);
                    if (v >= int'(lim_low) && v <= int'(lim_high))
                    begin
                        p_target = v[SPEED_W-1:0];
                        r.target_updated = 1'b1;
                    end
                end
                p_armed = 1'b0;
                clear_line();
            end
        end
        else if (c == ARM_BYTE)
        begin
            clear_line();
            p_armed = 1'b1;
        end
        else if (p_len >= LINE_MAX_DEFAULT)
        begin
            // The byte that would overrun the line buffer empties it instead.
            clear_line();
        end
        else
        begin
            if (p_len == 0)
            begin
                p_sign = (c == PLUS_BYTE)  ? SIGN_PLUS :
                         (c == MINUS_BYTE) ? SIGN_MINUS : SIGN_BAD;
            end
            else if (p_open)
            begin
                if (c >= ZERO_BYTE && c <= NINE_BYTE)
                begin
                    m = int'(p_mag) * 10 + int'(c - ZERO_BYTE);
                    p_mag = (m > int'(MAG_MAX)) ? MAG_MAX : m[SPEED_W-1:0];
                end
                else
                begin
                    p_open = 1'b0;
                end
            end
            p_len = p_len + 1'b1;
        end
        r.echo_byte    = c;
        r.target_speed = p_target;
        r.armed_flag   = p_armed;
        return r;
    endfunction

    // Offers one byte and records what the block must answer once it is taken.
    task automatic send_byte(input logic [7:0] b, input bit use_fixed = 1'b0,
                             input result_t fixed = '0);
        int      gap;
        result_t r;
        gap = 0;
        while (snd_idle_en && $urandom_range(0, 99) < 28)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        r = parse_byte(b);
        reply_q.push_back(use_fixed ? fixed : r);
        phase_items++;
        @(negedge clk);
    endtask

    task automatic write_limit(input logic reg_idx, input logic signed [SPEED_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {{(32-SPEED_W){val[SPEED_W-1]}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == REG_SPEED_LOW)
            lim_low = val;
        else
            lim_high = val;
        @(negedge clk);
    endtask

    function automatic logic [7:0] junk_byte();
        logic [7:0] j;
        do
            j = 8'($urandom_range(0, 255));
        while ((j >= ZERO_BYTE && j <= NINE_BYTE) || j == CR_BYTE || j == ARM_BYTE);
        return j;
    endfunction

    // One random command line: mostly well formed, the rest broken or noise.
    task automatic send_command();
        int         kind;
        int         pick;
        int         mag;
        int         val;
        int         n;
        bit         neg;
        logic [7:0] digits [$];
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            send_byte(ARM_BYTE);
            pick = $urandom_range(0, 99);
            neg  = $urandom_range(0, 1);
            if (pick < 55)
            begin
                mag = $urandom_range(0, 2048);
            end
            else if (pick < 70)
            begin
                val = ($urandom_range(0, 1) ? int'(lim_low) : int'(lim_high))
                      + int'($urandom_range(0, 2)) - 1;
                if (val != 0)
                    neg = (val < 0);
                mag = (val < 0) ? -val : val;
            end
            else if (pick < 80)
            begin
                mag = $urandom_range(4000, 99999);
            end
            else if (pick < 95)
            begin
                mag = $urandom_range(0, 20);
            end
            else
            begin
                mag = -1;
            end
            send_byte(neg ? MINUS_BYTE : PLUS_BYTE);
            if (mag >= 0)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_byte(ZERO_BYTE);
                do
                begin
                    digits.push_front(8'(int'(ZERO_BYTE) + mag % 10));
                    mag = mag / 10;
                end
                while (mag > 0);
                foreach (digits[i])
                    send_byte(digits[i]);
            end
            // Digits after a non-digit must not count.
            if ($urandom_range(0, 4) == 0)
            begin
                send_byte(junk_byte());
                send_byte(8'(int'(ZERO_BYTE) + int'($urandom_range(0, 9))));
            end
            send_byte(CR_BYTE);
        end
        else if (kind < 78)
        begin
            send_byte(ARM_BYTE);
            repeat ($urandom_range(0, 4))
                send_byte(junk_byte());
            send_byte(CR_BYTE);
        end
        else if (kind < 86)
        begin
            send_byte(ARM_BYTE);
            send_byte($urandom_range(0, 1) ? PLUS_BYTE : MINUS_BYTE);
            n = $urandom_range(9, 13);
            repeat (n)
                send_byte(8'(int'(ZERO_BYTE) + int'($urandom_range(0, 9))));
            send_byte(CR_BYTE);
        end
        else if (kind < 94)
        begin
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            send_byte(CR_BYTE);
        end
    endtask

    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (reply_q.size() == 0)
            begin
                $error("unexpected result transaction: %h", m_tdata);
                errors++;
            end
            else
            begin
                r = reply_q.pop_front();
                if (m_tdata[7:0] !== r.echo_byte)
                begin
                    $error("echo_byte: expected %0h, got %0h", r.echo_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[19:8] !== r.target_speed)
                begin
                    $error("target_speed: expected %0d, got %0d",
                           r.target_speed, $signed(m_tdata[19:8]));
                    errors++;
                end
                if (m_tdata[20] !== r.target_updated)
                begin
                    $error("target_updated: expected %0b, got %0b",
                           r.target_updated, m_tdata[20]);
                    errors++;
                end
                if (m_tdata[21] !== r.armed_flag)
                begin
                    $error("armed_flag: expected %0b, got %0b", r.armed_flag, m_tdata[21]);
                    errors++;
                end
                if (m_tdata[23:22] !== 2'b00)
                begin
                    $error("pad bits: expected 0, got %0b", m_tdata[23:22]);
                    errors++;
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        bit stall_done;
        stall_done = 1'b0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req && !stall_done)
            begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(negedge clk);
            end
            m_tready <= rcv_idle_en ? ($urandom_range(0, 99) >= 28) : 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [SPEED_W-1:0] lo;
        logic signed [SPEED_W-1:0] hi;
        result_t                   fixed;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        phase_items = 0;
        snd_idle_en = 1'b1;
        rcv_idle_en = 1'b1;
        stall_req   = 1'b0;
        p_armed     = 1'b0;
        p_target    = '0;
        lim_low     = SPEED_LOW_RESET;
        lim_high    = SPEED_HIGH_RESET;
        clear_line();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (cmd_rows[i])
        begin
            fixed.echo_byte      = cmd_rows[i].rx;
            fixed.target_speed   = cmd_rows[i].tgt;
            fixed.target_updated = cmd_rows[i].upd;
            fixed.armed_flag     = cmd_rows[i].arm;
            send_byte(cmd_rows[i].rx, cmd_rows[i].typed, fixed);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            s_tvalid <= 1'b0;
            while (reply_q.size() != 0)
                @(negedge clk);
            repeat (2) @(negedge clk);
            case (ph)
                0:
                begin
                    lo = SPEED_LOW_RESET;
                    hi = SPEED_HIGH_RESET;
                end
                1:
                begin
                    lo = -12'sd100;
                    hi = 12'sd250;
                end
                2:
                begin
                    lo = 12'sd0;
                    hi = 12'sd0;
                end
                3:
                begin
                    // Crossed limits: nothing passes.
                    lo = 12'sd300;
                    hi = -12'sd300;
                end
                4:
                begin
                    lo = -12'sd2048;
                    hi = -12'sd2048;
                end
                5:
                begin
                    lo = 12'sd2047;
                    hi = 12'sd2047;
                end
                default:
                begin
                    lo = 12'($urandom_range(0, 4095));
                    hi = 12'($urandom_range(0, 4095));
                end
            endcase
            write_limit(REG_SPEED_LOW, lo);
            write_limit(REG_SPEED_HIGH, hi);

            // Phase 1 keeps the sender busy while the receiver holds off;
            // phase 2 runs with no idling on either side.
            snd_idle_en = (ph != 1) && (ph != 2);
            rcv_idle_en = (ph != 2);
            if (ph == 1)
                stall_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_command();
        end
        s_tvalid <= 1'b0;

        while (reply_q.size() != 0)
            @(negedge clk);
        repeat (5) @(posedge clk);
        if (errors == 0 && reply_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/sscp_pkg.sv
rtl/core/sscp_cfg.sv
rtl/core/sscp_step.sv
rtl/core/signed_speed_command_parser_top.sv
tb/tb_signed_speed_command_parser_top.sv
